// File: hw/rtl/battery_charge_phase_controller_top_assert.svh
// Assertion macros used by the charge controller top.
`ifndef BATTERY_CHARGE_PHASE_CONTROLLER_TOP_ASSERT_SVH
`define BATTERY_CHARGE_PHASE_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BCPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bcpc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BCPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bcpc: next-cycle check failed");

`endif

// File: hw/rtl/bcpc_pkg.sv
`timescale 1ns / 1ps

package bcpc_pkg;

  // Charge phase codes as reported on the phase output
  typedef enum logic [2:0] {
    PH_STARTUP = 3'd0,
    PH_IDLE    = 3'd1,
    PH_BULK    = 3'd2,
    PH_ABSORB  = 3'd3,
    PH_END     = 3'd4
  } phase_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_LOW_BATTERY_MV    = 3'd0,
    REG_BULK_VOLTAGE_MV   = 3'd1,
    REG_BULK_CURRENT_MA   = 3'd2,
    REG_BULK_END_MV       = 3'd3,
    REG_ABSORB_VOLTAGE_MV = 3'd4,
    REG_ABSORB_CURRENT_MA = 3'd5,
    REG_ABSORB_END_MA     = 3'd6,
    REG_END_HOLD_TICKS    = 3'd7
  } cfg_reg_e;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ValW    = 16;

  // Reset values of the configuration registers
  localparam logic [ValW-1:0] RstLowBatteryMv    = 16'd13200;
  localparam logic [ValW-1:0] RstBulkVoltageMv   = 16'd14600;
  localparam logic [ValW-1:0] RstBulkCurrentMa   = 16'd8000;
  localparam logic [ValW-1:0] RstBulkEndMv       = 16'd14400;
  localparam logic [ValW-1:0] RstAbsorbVoltageMv = 16'd14400;
  localparam logic [ValW-1:0] RstAbsorbCurrentMa = 16'd6000;
  localparam logic [ValW-1:0] RstAbsorbEndMa     = 16'd2000;
  localparam logic [ValW-1:0] RstEndHoldTicks    = 16'd240;

  // Reset values of the held setpoints
  localparam logic [ValW-1:0] RstVoltageSetpoint = 16'd12000;
  localparam logic [ValW-1:0] RstCurrentLimit    = 16'd500;

  typedef struct packed {
    logic [ValW-1:0] low_battery_mv;
    logic [ValW-1:0] bulk_voltage_mv;
    logic [ValW-1:0] bulk_current_ma;
    logic [ValW-1:0] bulk_end_mv;
    logic [ValW-1:0] absorb_voltage_mv;
    logic [ValW-1:0] absorb_current_ma;
    logic [ValW-1:0] absorb_end_ma;
    logic [ValW-1:0] end_hold_ticks;
  } cfg_t;

  typedef struct packed {
    phase_e          phase;
    logic [ValW-1:0] voltage_setpoint_mv;
    logic [ValW-1:0] current_limit_ma;
    logic            output_on;
    logic            led_level;
    logic            fast_blink;
  } result_t;

endpackage

// File: hw/rtl/bcpc_cfg_regs.sv
`timescale 1ns / 1ps

module bcpc_cfg_regs
  import bcpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ValW-1:0]    cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  // Write one register per enabled cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_battery_mv    <= RstLowBatteryMv;
      cfg_q.bulk_voltage_mv   <= RstBulkVoltageMv;
      cfg_q.bulk_current_ma   <= RstBulkCurrentMa;
      cfg_q.bulk_end_mv       <= RstBulkEndMv;
      cfg_q.absorb_voltage_mv <= RstAbsorbVoltageMv;
      cfg_q.absorb_current_ma <= RstAbsorbCurrentMa;
      cfg_q.absorb_end_ma     <= RstAbsorbEndMa;
      cfg_q.end_hold_ticks    <= RstEndHoldTicks;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LOW_BATTERY_MV:    cfg_q.low_battery_mv    <= cfg_data_i;
        REG_BULK_VOLTAGE_MV:   cfg_q.bulk_voltage_mv   <= cfg_data_i;
        REG_BULK_CURRENT_MA:   cfg_q.bulk_current_ma   <= cfg_data_i;
        REG_BULK_END_MV:       cfg_q.bulk_end_mv       <= cfg_data_i;
        REG_ABSORB_VOLTAGE_MV: cfg_q.absorb_voltage_mv <= cfg_data_i;
        REG_ABSORB_CURRENT_MA: cfg_q.absorb_current_ma <= cfg_data_i;
        REG_ABSORB_END_MA:     cfg_q.absorb_end_ma     <= cfg_data_i;
        REG_END_HOLD_TICKS:    cfg_q.end_hold_ticks    <= cfg_data_i;
        default:               ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/bcpc_phase_fsm.sv
`timescale 1ns / 1ps

module bcpc_phase_fsm
  import bcpc_pkg::*;
#(
  parameter int unsigned STARTUP_TICKS = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [ValW-1:0] measured_mv_i,
  input  logic [ValW-1:0] measured_ma_i,
  input  cfg_t            cfg_i,
  output result_t         result_o
);

  localparam logic [ValW-1:0] StartupTicks = ValW'(STARTUP_TICKS);

  phase_e          phase_q, phase_d;
  logic [ValW-1:0] count_q, count_d;
  logic [ValW-1:0] vset_q, vset_d;
  logic [ValW-1:0] ilim_q, ilim_d;
  logic            led_q, led_d;
  logic            out_on_q, out_on_d;
  logic            fast;
  phase_e          acted;
  logic [ValW-1:0] count_inc;

  assign count_inc = count_q + ValW'(1);

  // Next phase and tick count
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    unique case (phase_q)
      PH_STARTUP: begin
        count_d = count_inc;
        if (count_inc >= StartupTicks) begin
          phase_d = PH_BULK;
          count_d = '0;
        end
      end
      PH_BULK: begin
        if (measured_mv_i >= cfg_i.bulk_end_mv) phase_d = PH_ABSORB;
      end
      PH_ABSORB: begin
        if (measured_ma_i < cfg_i.absorb_end_ma) begin
          phase_d = PH_END;
          count_d = '0;
        end
      end
      PH_END: begin
        count_d = count_inc;
        if (count_inc >= cfg_i.end_hold_ticks) begin
          phase_d = PH_IDLE;
          count_d = '0;
        end
      end
      default: begin
        // Idle, and any unused code acting as idle
        phase_d = (measured_mv_i <= cfg_i.low_battery_mv) ? PH_BULK : PH_IDLE;
      end
    endcase
  end

  // Setpoints, output enable, LED and blink flag
  always_comb begin
    vset_d   = vset_q;
    ilim_d   = ilim_q;
    led_d    = led_q;
    out_on_d = out_on_q;
    fast     = 1'b0;
    acted    = phase_q;
    unique case (phase_q)
      PH_STARTUP: begin
        out_on_d = 1'b0;
      end
      PH_BULK: begin
        vset_d   = cfg_i.bulk_voltage_mv;
        ilim_d   = cfg_i.bulk_current_ma;
        out_on_d = 1'b1;
        led_d    = 1'b0;
      end
      PH_ABSORB: begin
        vset_d   = cfg_i.absorb_voltage_mv;
        ilim_d   = cfg_i.absorb_current_ma;
        out_on_d = 1'b1;
        led_d    = ~led_q;
      end
      PH_END: begin
        out_on_d = 1'b0;
        led_d    = 1'b1;
        fast     = 1'b1;
      end
      default: begin
        acted    = PH_IDLE;
        out_on_d = 1'b0;
        led_d    = 1'b1;
      end
    endcase
  end

  // Advance the state on each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_STARTUP;
      count_q  <= '0;
      vset_q   <= RstVoltageSetpoint;
      ilim_q   <= RstCurrentLimit;
      led_q    <= 1'b1;
      out_on_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      vset_q   <= vset_d;
      ilim_q   <= ilim_d;
      led_q    <= led_d;
      out_on_q <= out_on_d;
    end
  end

  assign result_o.phase               = acted;
  assign result_o.voltage_setpoint_mv = vset_d;
  assign result_o.current_limit_ma    = ilim_d;
  assign result_o.output_on           = out_on_d;
  assign result_o.led_level           = led_d;
  assign result_o.fast_blink          = fast;

endmodule

// File: hw/rtl/battery_charge_phase_controller_top.sv
`timescale 1ns / 1ps
//  channel  | valid        | stall       | payload
//  input    | in_valid_i   | in_stall_o  | measured_mv_i, measured_ma_i
//  result   | out_valid_o  | out_stall_i | phase_o, voltage_setpoint_mv_o, current_limit_ma_o,
//           |              |             | output_on_o, led_level_o, fast_blink_o
//
//  One item per cycle sustained while out_stall_i is low; an item passes the input register
//  and then the result register. The phase machine steps when an item moves from the input
//  register into the result register, so one item is one charge tick.
//  Reset clears valid flags, count, enable; sets startup phase, LED high and reset setpoints.
//  A stalled result holds; the input register still takes an item while it is empty.

module battery_charge_phase_controller_top
  import bcpc_pkg::*;
#(
  parameter int unsigned STARTUP_TICKS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ValW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ValW-1:0]    measured_mv_i,
  input  logic [ValW-1:0]    measured_ma_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         phase_o,
  output logic [ValW-1:0]    voltage_setpoint_mv_o,
  output logic [ValW-1:0]    current_limit_ma_o,
  output logic               output_on_o,
  output logic               led_level_o,
  output logic               fast_blink_o
);

`include "battery_charge_phase_controller_top_assert.svh"

  cfg_t            cfg;
  result_t         fsm_result;
  result_t         result_q;
  logic            in_valid_q;
  logic [ValW-1:0] mv_q;
  logic [ValW-1:0] ma_q;
  logic            out_valid_q;
  logic            out_free;
  logic            advance;

  bcpc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: result slot frees when empty or taken; input moves when slot frees
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      mv_q <= measured_mv_i;
      ma_q <= measured_ma_i;
    end
  end

  bcpc_phase_fsm #(
    .STARTUP_TICKS (STARTUP_TICKS)
  ) u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .measured_mv_i (mv_q),
    .measured_ma_i (ma_q),
    .cfg_i         (cfg),
    .result_o      (fsm_result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= fsm_result;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign phase_o               = result_q.phase;
  assign voltage_setpoint_mv_o = result_q.voltage_setpoint_mv;
  assign current_limit_ma_o    = result_q.current_limit_ma;
  assign output_on_o           = result_q.output_on;
  assign led_level_o           = result_q.led_level;
  assign fast_blink_o          = result_q.fast_blink;

  // Checks on phase outputs and the stage handshake
  `BCPC_ASSERT_IMP(a_on_only_charging, clk_i, rst_ni, out_valid_o && output_on_o, phase_o == PH_BULK || phase_o == PH_ABSORB)
  `BCPC_ASSERT_IMP(a_blink_in_end, clk_i, rst_ni, out_valid_o && fast_blink_o, phase_o == PH_END && !output_on_o && led_level_o)
  `BCPC_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `BCPC_ASSERT_NXT(a_advance_shows, clk_i, rst_ni, advance, out_valid_o)

endmodule

// File: bench/battery_charge_phase_controller_top_tb.sv
`timescale 1ns / 1ps

module battery_charge_phase_controller_top_tb;
  import bcpc_pkg::*;

  localparam int unsigned StartupTicks = 10;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned ItemsPerSet  = 50;
  localparam int unsigned SettingSets  = 8;

  typedef struct packed {
    logic [ValW-1:0] mv;
    logic [ValW-1:0] ma;
  } tick_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [ValW-1:0]    cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [ValW-1:0]    measured_mv_i = '0;
  logic [ValW-1:0]    measured_ma_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         phase_o;
  logic [ValW-1:0]    voltage_setpoint_mv_o;
  logic [ValW-1:0]    current_limit_ma_o;
  logic               output_on_o;
  logic               led_level_o;
  logic               fast_blink_o;

  battery_charge_phase_controller_top #(
    .STARTUP_TICKS(StartupTicks)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .measured_mv_i        (measured_mv_i),
    .measured_ma_i        (measured_ma_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .phase_o              (phase_o),
    .voltage_setpoint_mv_o(voltage_setpoint_mv_o),
    .current_limit_ma_o   (current_limit_ma_o),
    .output_on_o          (output_on_o),
    .led_level_o          (led_level_o),
    .fast_blink_o         (fast_blink_o)
  );

  // Ticks waiting to be sent and tick reports still to arrive
  tick_t       pending_ticks[$];
  result_t     expected_reports[$];
  int unsigned ticks_queued    = 0;
  int unsigned reports_checked = 0;
  int unsigned mismatch_count  = 0;
  int unsigned send_gap        = 0;
  int unsigned stall_left      = 0;
  int unsigned quiet_cycles    = 0;
  bit          burst_mode      = 1'b0;

  // Shadow of the register file and of the charge state
  cfg_t            shadow_cfg;
  phase_e          ch_phase   = PH_STARTUP;
  logic [ValW-1:0] tick_cnt   = '0;
  logic [ValW-1:0] hold_v     = RstVoltageSetpoint;
  logic [ValW-1:0] hold_i     = RstCurrentLimit;
  logic            led        = 1'b1;
  logic            out_en     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Step the charge phase by one tick and return the report it yields
  function automatic result_t charge_tick(logic [ValW-1:0] mv, logic [ValW-1:0] ma);
    result_t r;
    r.phase      = ch_phase;
    r.fast_blink = 1'b0;
    case (ch_phase)
      PH_STARTUP: begin
        out_en   = 1'b0;
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= StartupTicks) begin
          ch_phase = PH_BULK;
          tick_cnt = '0;
        end
      end
      PH_BULK: begin
        hold_v = shadow_cfg.bulk_voltage_mv;
        hold_i = shadow_cfg.bulk_current_ma;
        out_en = 1'b1;
        led    = 1'b0;
        if (mv >= shadow_cfg.bulk_end_mv) ch_phase = PH_ABSORB;
      end
      PH_ABSORB: begin
        hold_v = shadow_cfg.absorb_voltage_mv;
        hold_i = shadow_cfg.absorb_current_ma;
        out_en = 1'b1;
        led    = ~led;
        if (ma < shadow_cfg.absorb_end_ma) begin
          ch_phase = PH_END;
          tick_cnt = '0;
        end
      end
      PH_END: begin
        out_en       = 1'b0;
        led          = 1'b1;
        r.fast_blink = 1'b1;
        tick_cnt     = tick_cnt + 1'b1;
        // a zero hold count still spends one tick here
        if (tick_cnt >= shadow_cfg.end_hold_ticks) begin
          ch_phase = PH_IDLE;
          tick_cnt = '0;
        end
      end
      default: begin
        r.phase  = PH_IDLE;
        ch_phase = PH_IDLE;
        out_en   = 1'b0;
        led      = 1'b1;
        if (mv <= shadow_cfg.low_battery_mv) ch_phase = PH_BULK;
      end
    endcase
    r.voltage_setpoint_mv = hold_v;
    r.current_limit_ma    = hold_i;
    r.output_on           = out_en;
    r.led_level           = led;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none in burst mode
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ValW-1:0] clamp16(int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[ValW-1:0];
  endfunction

  function automatic logic [ValW-1:0] near(logic [ValW-1:0] center);
    return clamp16(int'(center) + int'($urandom_range(0, 8)) - 4);
  endfunction

  // Pick a threshold: mostly around its default, sometimes an extreme
  function automatic logic [ValW-1:0] rand_level(logic [ValW-1:0] dflt);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return ValW'($urandom_range(0, 65535));
    return clamp16(int'(dflt) + int'($urandom_range(0, 4000)) - 2000);
  endfunction

  // Aim readings at the live thresholds so every phase gets left and entered
  function automatic tick_t rand_tick();
    tick_t t;
    case ($urandom_range(0, 7))
      0:       t.mv = '0;
      1:       t.mv = '1;
      2, 3:    t.mv = near(shadow_cfg.bulk_end_mv);
      4:       t.mv = near(shadow_cfg.low_battery_mv);
      default: t.mv = ValW'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 7))
      0:       t.ma = '0;
      1:       t.ma = '1;
      2, 3, 4: t.ma = near(shadow_cfg.absorb_end_ma);
      default: t.ma = ValW'($urandom_range(0, 65535));
    endcase
    return t;
  endfunction

  function automatic cfg_t default_cfg();
    cfg_t c;
    c.low_battery_mv    = RstLowBatteryMv;
    c.bulk_voltage_mv   = RstBulkVoltageMv;
    c.bulk_current_ma   = RstBulkCurrentMa;
    c.bulk_end_mv       = RstBulkEndMv;
    c.absorb_voltage_mv = RstAbsorbVoltageMv;
    c.absorb_current_ma = RstAbsorbCurrentMa;
    c.absorb_end_ma     = RstAbsorbEndMa;
    c.end_hold_ticks    = RstEndHoldTicks;
    return c;
  endfunction

  // Write every register; the first field of cfg_t is register zero
  task automatic write_settings(cfg_t c);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_reg_e'(i);
      cfg_data_i <= c[ValW*(7-i) +: ValW];
    end
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    shadow_cfg = c;
  endtask

  task automatic queue_tick(logic [ValW-1:0] mv, logic [ValW-1:0] ma);
    tick_t t;
    t.mv = mv;
    t.ma = ma;
    pending_ticks.push_back(t);
    ticks_queued++;
  endtask

  // Hold the sender until every queued tick has reported, then let the pipe drain
  task automatic settle();
    while (reports_checked != ticks_queued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Drive ticks from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_reports.push_back(charge_tick(measured_mv_i,
                                                                              measured_ma_i));
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (pending_ticks.size() > 0) begin
          in_valid_i    <= 1'b1;
          measured_mv_i <= pending_ticks[0].mv;
          measured_ma_i <= pending_ticks[0].ma;
          void'(pending_ticks.pop_front());
          send_gap      <= draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [ValW-1:0] want, logic [ValW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Check reports against the oldest expectation and stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report: phase %0d", phase_o);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("phase", ValW'(want.phase), ValW'(phase_o));
          compare_field("voltage_setpoint_mv", want.voltage_setpoint_mv, voltage_setpoint_mv_o);
          compare_field("current_limit_ma", want.current_limit_ma, current_limit_ma_o);
          compare_field("output_on", ValW'(want.output_on), ValW'(output_on_o));
          compare_field("led_level", ValW'(want.led_level), ValW'(led_level_o));
          compare_field("fast_blink", ValW'(want.fast_blink), ValW'(fast_blink_o));
          reports_checked++;
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else begin
        int unsigned len;
        len = draw_gap();
        out_stall_i <= (len > 0);
        stall_left  <= (len > 0) ? len - 1 : 0;
      end
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("FAIL battery_charge_phase_controller_top");
        $finish;
      end
    end
  end

  initial begin
    cfg_t set;
    shadow_cfg = default_cfg();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk through every phase with a zero end hold
    set = default_cfg();
    set.end_hold_ticks = '0;
    write_settings(set);
    for (int i = 0; i < StartupTicks; i++) queue_tick((i % 2) ? '1 : '0, (i % 2) ? '0 : '1);
    queue_tick(16'd14399, 16'd0);      // just under bulk end
    queue_tick(16'd14400, 16'd0);      // bulk end reached
    queue_tick(16'd0, 16'd2000);       // absorb end not yet crossed
    queue_tick(16'd0, 16'hffff);
    queue_tick(16'd0, 16'd1999);       // into end hold
    queue_tick(16'd0, 16'd0);          // single end tick
    queue_tick(16'd13201, 16'd0);      // idle just above low battery
    queue_tick(16'hffff, 16'hffff);
    queue_tick(16'd13200, 16'd0);      // low battery restarts bulk
    queue_tick(16'hffff, 16'd0);
    queue_tick(16'd0, 16'd0);
    queue_tick(16'd0, 16'd0);
    queue_tick(16'd0, 16'hffff);
    settle();

    // Random ticks under a series of register settings
    for (int s = 0; s < SettingSets; s++) begin
      case (s)
        0: set = '0;
        1: set = '1;
        2: begin
          set = default_cfg();
          set.end_hold_ticks = 16'd1;
        end
        default: begin
          set.low_battery_mv    = rand_level(RstLowBatteryMv);
          set.bulk_voltage_mv   = rand_level(RstBulkVoltageMv);
          set.bulk_current_ma   = rand_level(RstBulkCurrentMa);
          set.bulk_end_mv       = rand_level(RstBulkEndMv);
          set.absorb_voltage_mv = rand_level(RstAbsorbVoltageMv);
          set.absorb_current_ma = rand_level(RstAbsorbCurrentMa);
          set.absorb_end_ma     = rand_level(RstAbsorbEndMa);
          set.end_hold_ticks    = ($urandom_range(0, 9) == 0) ? 16'd20
                                                               : ValW'($urandom_range(0, 6));
        end
      endcase
      write_settings(set);
      burst_mode = (s == 2) || (s == 5);
      for (int i = 0; i < ItemsPerSet; i++) pending_ticks.push_back(rand_tick());
      ticks_queued += ItemsPerSet;
      settle();
    end

    if (mismatch_count == 0) begin
      $display("PASS battery_charge_phase_controller_top");
    end else begin
      $display("FAIL battery_charge_phase_controller_top");
    end
    $finish;
  end

endmodule

// File: battery_charge_phase_controller_top.f
+incdir+hw/rtl
hw/rtl/bcpc_pkg.sv
hw/rtl/bcpc_cfg_regs.sv
hw/rtl/bcpc_phase_fsm.sv
hw/rtl/battery_charge_phase_controller_top.sv
bench/battery_charge_phase_controller_top_tb.sv
